// ===== hw/rtl/ssu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SSU parser package
// Phase codes, field kinds and result status codes shared by the parser.
// ----------------------------------------------------------------------------
package ssu_pkg;

    typedef enum logic [4:0] {
        PH_MAC    = 5'd0,  PH_IV     = 5'd1,  PH_FLAG   = 5'd2,  PH_TIME   = 5'd3,
        PH_KEY    = 5'd4,  PH_EXTSZ  = 5'd5,  PH_EXT    = 5'd6,  PH_DH     = 5'd7,
        PH_ADDRSZ = 5'd8,  PH_ADDR   = 5'd9,  PH_PORT   = 5'd10, PH_TAG    = 5'd11,
        PH_STIME  = 5'd12, PH_CHALSZ = 5'd13, PH_CHAL   = 5'd14, PH_IKEY   = 5'd15,
        PH_NONCE  = 5'd16, PH_REST   = 5'd17, PH_DFLAGS = 5'd18, PH_NEXP   = 5'd19,
        PH_EXP    = 5'd20, PH_NACK   = 5'd21, PH_ACK    = 5'd22, PH_BITF   = 5'd23,
        PH_DEXTSZ = 5'd24, PH_DEXT   = 5'd25, PH_NFRAG  = 5'd26, PH_FMSG   = 5'd27,
        PH_FINFO  = 5'd28, PH_FDATA  = 5'd29, PH_DONE   = 5'd30, PH_DRAIN  = 5'd31
    } phase_t;

    localparam logic [4:0] CODE_CLOSE = 5'd31;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd3;

    localparam logic [3:0] MAX_KIND  = 4'd8;
    localparam logic [3:0] LAST_STEP = 4'd8;

    typedef enum logic [2:0] {
        K_BYTES = 3'd0, K_INT = 3'd1, K_SKIP = 3'd2, K_REST = 3'd3, K_IDLE = 3'd4
    } kind_t;

    function automatic kind_t phase_kind(input phase_t ph);
        kind_t k;
        case (ph)
            PH_MAC, PH_IV, PH_EXT, PH_DH, PH_ADDR, PH_CHAL, PH_IKEY, PH_DEXT,
            PH_FDATA: k = K_BYTES;
            PH_KEY: k = K_SKIP;
            PH_REST: k = K_REST;
            PH_DONE, PH_DRAIN: k = K_IDLE;
            default: k = K_INT;
        endcase
        return k;
    endfunction

    // Body program: phase at a given step of a payload type.
    function automatic phase_t body_prog(input logic [3:0] kind, input logic [3:0] step);
        phase_t p;
        p = PH_DONE;
        case (kind)
            4'd0: case (step)
                4'd0: p = PH_DH; 4'd1: p = PH_ADDRSZ; 4'd2: p = PH_ADDR;
                default: p = PH_DONE;
            endcase
            4'd1: case (step)
                4'd0: p = PH_DH; 4'd1: p = PH_ADDRSZ; 4'd2: p = PH_ADDR;
                4'd3: p = PH_PORT; 4'd4: p = PH_TAG; 4'd5: p = PH_STIME;
                4'd6: p = PH_REST; default: p = PH_DONE;
            endcase
            4'd2: case (step)
                4'd0: p = PH_REST; default: p = PH_DONE;
            endcase
            4'd3: case (step)
                4'd0: p = PH_TAG; 4'd1: p = PH_ADDRSZ; 4'd2: p = PH_ADDR;
                4'd3: p = PH_PORT; 4'd4: p = PH_CHALSZ; 4'd5: p = PH_CHAL;
                4'd6: p = PH_IKEY; 4'd7: p = PH_NONCE; default: p = PH_DONE;
            endcase
            4'd4: case (step)
                4'd0: p = PH_ADDRSZ; 4'd1: p = PH_ADDR; 4'd2: p = PH_PORT;
                4'd3: p = PH_ADDRSZ; 4'd4: p = PH_ADDR; 4'd5: p = PH_PORT;
                4'd6: p = PH_NONCE; default: p = PH_DONE;
            endcase
            4'd5: case (step)
                4'd0: p = PH_ADDRSZ; 4'd1: p = PH_ADDR; 4'd2: p = PH_PORT;
                4'd3: p = PH_CHALSZ; 4'd4: p = PH_CHAL; default: p = PH_DONE;
            endcase
            4'd6: case (step)
                4'd0: p = PH_DFLAGS; default: p = PH_DONE;
            endcase
            4'd7: case (step)
                4'd0: p = PH_NONCE; 4'd1: p = PH_ADDRSZ; 4'd2: p = PH_ADDR;
                4'd3: p = PH_PORT; 4'd4: p = PH_IKEY; default: p = PH_DONE;
            endcase
            default: p = PH_DONE;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssu_packet_field_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SSU packet field parser
// Streams packet bytes in and emits parsed header and body fields.
// ----------------------------------------------------------------------------
// One packet byte is taken per transfer, with s_last_byte on the final byte.
// The parser walks the header (MAC, IV, flag byte, time, optional keying
// material, optional extended options) and then the body of the type that the
// flag byte selects. Integers come out whole when their last byte arrives,
// byte fields one result per byte. The final byte of a packet always makes a
// result (a closing marker, code 31, if nothing else) carrying m_packet_end
// and the parse status. Throughput is one byte per cycle: each byte advances
// the parse state, and a single output register holds the result; the input
// stalls only while that register is full and not taken. Zero sized fields
// are skipped in the same cycle; a chain of empty fields resolves through
// combinational checks on each kind of pending-length field.
// ----------------------------------------------------------------------------
module ssu_packet_field_parser #(
    parameter int MAC_BYTES        = 16,
    parameter int IV_BYTES         = 16,
    parameter int KEYING_BYTES     = 64,
    parameter int DH_BYTES         = 256,
    parameter int INTRO_KEY_BYTES  = 32,
    parameter int HEADER_MIN_BYTES = 37
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_field_code,
    output logic [31:0]      m_field_value,
    output logic             m_field_last,
    output logic             m_packet_end,
    output logic [1:0]       m_parse_status
);

    localparam logic [13:0] HDR_MIN = 14'(HEADER_MIN_BYTES);

    // Parse state
    ssu_pkg::phase_t phase_reg;
    logic [13:0] bytes_left_reg;
    logic [7:0]  seen_reg;
    logic [3:0]  kind_reg;
    logic [1:0]  hflags_reg;
    logic [7:0]  dflags_reg;
    logic [7:0]  items_reg;
    logic [31:0] accum_reg;
    logic        bad_reg;
    logic [13:0] pend_reg;
    logic [3:0]  step_reg;

    logic xfer;
    assign s_ready = !m_valid || m_ready;
    assign xfer    = s_valid && s_ready;

    // Length of a phase given a pending length.
    function automatic logic [13:0] field_len(input ssu_pkg::phase_t ph,
                                              input logic [13:0] pend);
        logic [13:0] l;
        case (ph)
            ssu_pkg::PH_MAC:  l = 14'(MAC_BYTES);
            ssu_pkg::PH_IV:   l = 14'(IV_BYTES);
            ssu_pkg::PH_KEY:  l = 14'(KEYING_BYTES);
            ssu_pkg::PH_DH:   l = 14'(DH_BYTES);
            ssu_pkg::PH_IKEY: l = 14'(INTRO_KEY_BYTES);
            ssu_pkg::PH_TIME, ssu_pkg::PH_TAG, ssu_pkg::PH_STIME, ssu_pkg::PH_NONCE,
            ssu_pkg::PH_EXP, ssu_pkg::PH_ACK, ssu_pkg::PH_FMSG: l = 14'd4;
            ssu_pkg::PH_FINFO: l = 14'd3;
            ssu_pkg::PH_PORT:  l = 14'd2;
            ssu_pkg::PH_EXT, ssu_pkg::PH_ADDR, ssu_pkg::PH_CHAL, ssu_pkg::PH_DEXT,
            ssu_pkg::PH_FDATA: l = pend;
            default: l = 14'd1;
        endcase
        return l;
    endfunction

    // Combinational next state
    ssu_pkg::phase_t phase_next;
    logic [13:0] bytes_left_next, pend_next;
    logic [3:0]  kind_next, step_next;
    logic [1:0]  hflags_next;
    logic [7:0]  dflags_next, items_next;
    logic [31:0] accum_next, v;
    logic        bad_next, made, flast, done_f;
    logic [4:0]  code;
    logic [31:0] value;
    logic [13:0] blm1;
    ssu_pkg::kind_t k;

    always_comb begin
        phase_next = phase_reg; bytes_left_next = bytes_left_reg; pend_next = pend_reg;
        kind_next = kind_reg; step_next = step_reg; hflags_next = hflags_reg;
        dflags_next = dflags_reg; items_next = items_reg; accum_next = accum_reg;
        bad_next = bad_reg;
        made = 1'b0; flast = 1'b0; code = ssu_pkg::CODE_CLOSE; value = '0;
        done_f = 1'b0; v = '0;
        k = ssu_pkg::phase_kind(phase_reg);
        blm1 = bytes_left_reg - 14'd1;
        case (k)
            ssu_pkg::K_BYTES: begin
                made = 1'b1; code = phase_reg; value = {24'd0, s_data_byte};
                flast = (bytes_left_reg == 14'd1);
                bytes_left_next = blm1; done_f = (blm1 == 14'd0);
            end
            ssu_pkg::K_SKIP: begin
                bytes_left_next = blm1; done_f = (blm1 == 14'd0);
            end
            ssu_pkg::K_INT: begin
                accum_next = {accum_reg[23:0], s_data_byte};
                bytes_left_next = blm1;
                if (blm1 == 14'd0) begin
                    made = 1'b1; code = phase_reg; value = accum_next; flast = 1'b1;
                    done_f = 1'b1; v = accum_next;
                end
            end
            ssu_pkg::K_REST: begin
                made = 1'b1; code = ssu_pkg::PH_REST; value = {24'd0, s_data_byte};
                flast = s_last_byte;
            end
            default: ;
        endcase

        // Finish the completed field and pick the next phase.
        if (done_f) begin
            case (phase_reg)
                ssu_pkg::PH_MAC: phase_next = ssu_pkg::PH_IV;
                ssu_pkg::PH_IV:  phase_next = ssu_pkg::PH_FLAG;
                ssu_pkg::PH_FLAG: begin
                    hflags_next = {v[2], v[3]}; kind_next = v[7:4];
                    if (v[7:4] > ssu_pkg::MAX_KIND) begin
                        bad_next = 1'b1; phase_next = ssu_pkg::PH_DRAIN;
                    end else phase_next = ssu_pkg::PH_TIME;
                end
                ssu_pkg::PH_TIME: begin
                    if (hflags_reg[0]) phase_next = ssu_pkg::PH_KEY;
                    else if (hflags_reg[1]) phase_next = ssu_pkg::PH_EXTSZ;
                    else begin
                        step_next = '0; phase_next = ssu_pkg::body_prog(kind_reg, 4'd0);
                    end
                end
                ssu_pkg::PH_KEY: begin
                    if (hflags_reg[1]) phase_next = ssu_pkg::PH_EXTSZ;
                    else begin
                        step_next = '0; phase_next = ssu_pkg::body_prog(kind_reg, 4'd0);
                    end
                end
                ssu_pkg::PH_EXTSZ: begin
                    pend_next = {6'd0, v[7:0]}; phase_next = ssu_pkg::PH_EXT;
                end
                ssu_pkg::PH_EXT: begin
                    step_next = '0; phase_next = ssu_pkg::body_prog(kind_reg, 4'd0);
                end
                ssu_pkg::PH_ADDRSZ, ssu_pkg::PH_CHALSZ: begin
                    pend_next = {6'd0, v[7:0]};
                    step_next = step_reg + 4'd1;
                    phase_next = ssu_pkg::body_prog(kind_reg, step_next);
                end
                ssu_pkg::PH_DFLAGS: begin
                    dflags_next = v[7:0];
                    if (v[7]) phase_next = ssu_pkg::PH_NEXP;
                    else if (v[6]) phase_next = ssu_pkg::PH_NACK;
                    else if (v[1]) phase_next = ssu_pkg::PH_DEXTSZ;
                    else phase_next = ssu_pkg::PH_NFRAG;
                end
                ssu_pkg::PH_NEXP, ssu_pkg::PH_EXP: begin
                    items_next = (phase_reg == ssu_pkg::PH_NEXP) ? v[7:0]
                                                                 : items_reg - 8'd1;
                    if (items_next != 8'd0) phase_next = ssu_pkg::PH_EXP;
                    else if (dflags_reg[6]) phase_next = ssu_pkg::PH_NACK;
                    else if (dflags_reg[1]) phase_next = ssu_pkg::PH_DEXTSZ;
                    else phase_next = ssu_pkg::PH_NFRAG;
                end
                ssu_pkg::PH_NACK, ssu_pkg::PH_ACK: begin
                    items_next = (phase_reg == ssu_pkg::PH_NACK) ? v[7:0]
                                                                 : items_reg - 8'd1;
                    phase_next = (items_next != 8'd0) ? ssu_pkg::PH_ACK : ssu_pkg::PH_BITF;
                end
                ssu_pkg::PH_BITF: begin
                    if (v[7]) phase_next = ssu_pkg::PH_BITF;
                    else if (dflags_reg[1]) phase_next = ssu_pkg::PH_DEXTSZ;
                    else phase_next = ssu_pkg::PH_NFRAG;
                end
                ssu_pkg::PH_DEXTSZ: begin
                    pend_next = {6'd0, v[7:0]}; phase_next = ssu_pkg::PH_DEXT;
                end
                ssu_pkg::PH_DEXT: phase_next = ssu_pkg::PH_NFRAG;
                ssu_pkg::PH_NFRAG: begin
                    items_next = v[7:0];
                    phase_next = (items_next != 8'd0) ? ssu_pkg::PH_FMSG : ssu_pkg::PH_DONE;
                end
                ssu_pkg::PH_FMSG: phase_next = ssu_pkg::PH_FINFO;
                ssu_pkg::PH_FINFO: begin
                    pend_next = v[13:0]; phase_next = ssu_pkg::PH_FDATA;
                end
                ssu_pkg::PH_FDATA: begin
                    items_next = items_reg - 8'd1;
                    phase_next = (items_next != 8'd0) ? ssu_pkg::PH_FMSG : ssu_pkg::PH_DONE;
                end
                default: begin
                    step_next = step_reg + 4'd1;
                    phase_next = (step_reg >= ssu_pkg::LAST_STEP - 4'd1)
                               ? ssu_pkg::PH_DONE : ssu_pkg::body_prog(kind_reg, step_next);
                end
            endcase
            // Zero sized byte fields complete at once. Only pending-length
            // fields can be empty; resolve their successors.
            if (phase_next == ssu_pkg::PH_EXT && pend_next == 14'd0) begin
                step_next = '0; phase_next = ssu_pkg::body_prog(kind_next, 4'd0);
            end
            if ((phase_next == ssu_pkg::PH_ADDR || phase_next == ssu_pkg::PH_CHAL) &&
                pend_next == 14'd0) begin
                step_next = step_next + 4'd1;
                phase_next = ssu_pkg::body_prog(kind_next, step_next);
            end
            if (phase_next == ssu_pkg::PH_DEXT && pend_next == 14'd0)
                phase_next = ssu_pkg::PH_NFRAG;
            if (phase_next == ssu_pkg::PH_FDATA && pend_next == 14'd0) begin
                items_next = items_next - 8'd1;
                phase_next = (items_next != 8'd0) ? ssu_pkg::PH_FMSG : ssu_pkg::PH_DONE;
            end
            accum_next = '0;
            if (ssu_pkg::phase_kind(phase_next) == ssu_pkg::K_REST ||
                ssu_pkg::phase_kind(phase_next) == ssu_pkg::K_IDLE) bytes_left_next = '0;
            else bytes_left_next = field_len(phase_next, pend_next);
        end
    end

    // Packet byte count including this byte, saturating at the header minimum.
    logic [7:0]  seen_next;
    logic [1:0]  status;
    assign seen_next = (14'(seen_reg) < HDR_MIN) ? seen_reg + 8'd1 : seen_reg;

    always_comb begin
        if (14'(seen_next) < HDR_MIN) status = ssu_pkg::ST_SHORT;
        else if (bad_next) status = ssu_pkg::ST_BAD_TYPE;
        else if (phase_next == ssu_pkg::PH_DONE || phase_next == ssu_pkg::PH_REST)
            status = ssu_pkg::ST_OK;
        else status = ssu_pkg::ST_TRUNCATED;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ssu_pkg::PH_MAC;
            bytes_left_reg <= 14'(MAC_BYTES);
            seen_reg <= '0; kind_reg <= '0; hflags_reg <= '0; dflags_reg <= '0;
            items_reg <= '0; accum_reg <= '0; bad_reg <= 1'b0; pend_reg <= '0;
            step_reg <= '0; m_valid <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (xfer) begin
                if (s_last_byte) begin
                    // Start over for the next packet.
                    phase_reg <= ssu_pkg::PH_MAC;
                    bytes_left_reg <= 14'(MAC_BYTES);
                    seen_reg <= '0; kind_reg <= '0; hflags_reg <= '0; dflags_reg <= '0;
                    items_reg <= '0; accum_reg <= '0; bad_reg <= 1'b0; pend_reg <= '0;
                    step_reg <= '0;
                end else begin
                    phase_reg <= phase_next; bytes_left_reg <= bytes_left_next;
                    seen_reg <= seen_next;
                    kind_reg <= kind_next; hflags_reg <= hflags_next;
                    dflags_reg <= dflags_next;
                    items_reg <= items_next; accum_reg <= accum_next; bad_reg <= bad_next;
                    pend_reg <= pend_next; step_reg <= step_next;
                end
                if (made || s_last_byte) m_valid <= 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (xfer && (made || s_last_byte)) begin
            m_field_code   <= made ? code : ssu_pkg::CODE_CLOSE;
            m_field_value  <= made ? value : 32'd0;
            m_field_last   <= made ? flast : 1'b0;
            m_packet_end   <= s_last_byte;
            m_parse_status <= s_last_byte ? status : ssu_pkg::ST_OK;
        end
    end

endmodule
`default_nettype wire
